// ===== rtl/plcs_pkg.sv =====
// Shared constants, register codes and pipeline payload types of the contrast stretch.
`default_nettype none

package plcs_pkg;

    // Pixel width; every datapath width below follows from it.
    localparam int PIX_W  = 8;
    localparam int PROD_W = 2 * PIX_W;

    // Configuration port geometry: five registers at byte addresses 4*i.
    localparam int REG_CNT = 5;
    localparam int ADDR_W  = $clog2(4 * REG_CNT);
    localparam int IDX_W   = ADDR_W - 2;
    localparam int DATA_W  = 32;

    localparam logic [PIX_W-1:0] MAXV      = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] THR_RESET = PIX_W'(128);

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_KNEE_IN   = IDX_W'(0),
        REG_LOW_KNEE_OUT  = IDX_W'(1),
        REG_HIGH_KNEE_IN  = IDX_W'(2),
        REG_HIGH_KNEE_OUT = IDX_W'(3),
        REG_THRESHOLD     = IDX_W'(4)
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] low_knee_in;
        logic [PIX_W-1:0] low_knee_out;
        logic [PIX_W-1:0] high_knee_in;
        logic [PIX_W-1:0] high_knee_out;
        logic [PIX_W-1:0] threshold_level;
    } t_cfg;

    // Segment chosen: start value, sign and magnitude of the rise, distance and width.
    typedef struct packed {
        logic [PIX_W-1:0] start;
        logic             neg;
        logic [PIX_W-1:0] mag;
        logic [PIX_W-1:0] span;
        logic [PIX_W-1:0] width;
        logic             bin;
    } t_seg_s;

    // After the multiply: magnitude of rise times distance.
    typedef struct packed {
        logic [PIX_W-1:0]  start;
        logic              neg;
        logic [PROD_W-1:0] prod;
        logic [PIX_W-1:0]  width;
        logic              bin;
    } t_mul_s;

    // Divider stage: partial remainder and a shift word that trades dividend
    // bits for quotient bits, one per stage.
    typedef struct packed {
        logic [PIX_W-1:0] start;
        logic             neg;
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] sh;
        logic [PIX_W-1:0] width;
        logic             bin;
    } t_div_s;

endpackage

`default_nettype wire

// ===== rtl/plcs_cfg.sv =====
// APB-style register file holding the knee points and the threshold level.
`default_nettype none

module plcs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [plcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [plcs_pkg::DATA_W-1:0]   pwdata,
    output logic [plcs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output plcs_pkg::t_cfg                o_cfg
);
    import plcs_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_knee_in     <= '0;
            r_cfg.low_knee_out    <= '0;
            r_cfg.high_knee_in    <= MAXV;
            r_cfg.high_knee_out   <= MAXV;
            r_cfg.threshold_level <= THR_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_LOW_KNEE_IN:   r_cfg.low_knee_in     <= pwdata[PIX_W-1:0];
                REG_LOW_KNEE_OUT:  r_cfg.low_knee_out    <= pwdata[PIX_W-1:0];
                REG_HIGH_KNEE_IN:  r_cfg.high_knee_in    <= pwdata[PIX_W-1:0];
                REG_HIGH_KNEE_OUT: r_cfg.high_knee_out   <= pwdata[PIX_W-1:0];
                REG_THRESHOLD:     r_cfg.threshold_level <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LOW_KNEE_IN:   prdata = DATA_W'(r_cfg.low_knee_in);
            REG_LOW_KNEE_OUT:  prdata = DATA_W'(r_cfg.low_knee_out);
            REG_HIGH_KNEE_IN:  prdata = DATA_W'(r_cfg.high_knee_in);
            REG_HIGH_KNEE_OUT: prdata = DATA_W'(r_cfg.high_knee_out);
            REG_THRESHOLD:     prdata = DATA_W'(r_cfg.threshold_level);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/plcs_seg.sv =====
// Front of the pipeline: segment selection, then the rise-times-distance multiply.
`default_nettype none

module plcs_seg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  plcs_pkg::t_cfg            i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [plcs_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_valid,
    input  logic                      i_ready,
    output plcs_pkg::t_mul_s          o_data
);
    import plcs_pkg::*;

    logic   r_va;
    logic   r_vb;
    t_seg_s r_a;
    t_mul_s r_b;
    t_seg_s n_a;
    t_mul_s n_b;
    logic   rdy_a;
    logic   rdy_b;

    assign rdy_b   = !r_vb | i_ready;
    assign rdy_a   = !r_va | rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;
    assign o_data  = r_b;

    // Pick the segment the pixel falls in. The rise is kept as sign and magnitude
    // so that the divider works on unsigned values and truncates toward zero.
    always_comb begin
        n_a.bin = (i_pixel >= i_cfg.threshold_level);
        if (i_pixel < i_cfg.low_knee_in) begin
            n_a.start = '0;
            n_a.neg   = 1'b0;
            n_a.mag   = i_cfg.low_knee_out;
            n_a.span  = i_pixel;
            n_a.width = i_cfg.low_knee_in;
        end else if (i_pixel <= i_cfg.high_knee_in) begin
            n_a.start = i_cfg.low_knee_out;
            n_a.neg   = (i_cfg.high_knee_out < i_cfg.low_knee_out);
            n_a.mag   = n_a.neg ? (i_cfg.low_knee_out - i_cfg.high_knee_out)
                                : (i_cfg.high_knee_out - i_cfg.low_knee_out);
            n_a.span  = i_pixel - i_cfg.low_knee_in;
            n_a.width = i_cfg.high_knee_in - i_cfg.low_knee_in;
        end else begin
            n_a.start = i_cfg.high_knee_out;
            n_a.neg   = 1'b0;
            n_a.mag   = MAXV - i_cfg.high_knee_out;
            n_a.span  = i_pixel - i_cfg.high_knee_in;
            n_a.width = MAXV - i_cfg.high_knee_in;
        end
    end

    always_comb begin
        n_b.start = r_a.start;
        n_b.neg   = r_a.neg;
        n_b.prod  = PROD_W'(r_a.mag) * PROD_W'(r_a.span);
        n_b.width = r_a.width;
        n_b.bin   = r_a.bin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a <= n_a;
        end
        if (rdy_b && r_va) begin
            r_b <= n_b;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/plcs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module plcs_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  plcs_pkg::t_mul_s i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output plcs_pkg::t_div_s o_data
);
    import plcs_pkg::*;

    logic [PIX_W-1:0] r_v;
    t_div_s           r_s [PIX_W];
    t_div_s           n_s [PIX_W];
    logic [PIX_W:0]   rdy;
    t_div_s           first;

    // The product is below width * 2^PIX_W, so its upper half is already a
    // valid partial remainder and the quotient fits in PIX_W bits.
    always_comb begin
        first.start = i_data.start;
        first.neg   = i_data.neg;
        first.rem   = i_data.prod[PROD_W-1:PIX_W];
        first.sh    = i_data.prod[PIX_W-1:0];
        first.width = i_data.width;
        first.bin   = i_data.bin;
    end

    always_comb begin
        rdy[PIX_W] = i_ready;
        for (int k = PIX_W - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] | rdy[k+1];
        end
    end

    always_comb begin
        t_div_s         src;
        logic [PIX_W:0] tmp;
        logic           ge;
        for (int k = 0; k < PIX_W; k++) begin
            src = (k == 0) ? first : r_s[(k == 0) ? 0 : k - 1];
            tmp = {src.rem, src.sh[PIX_W-1]};
            ge  = (tmp >= {1'b0, src.width});
            n_s[k]       = src;
            n_s[k].rem   = ge ? PIX_W'(tmp - {1'b0, src.width}) : tmp[PIX_W-1:0];
            n_s[k].sh    = {src.sh[PIX_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < PIX_W; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PIX_W; k++) begin
            if (rdy[k] && ((k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1])) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[PIX_W-1];
    assign o_data  = r_s[PIX_W-1];

endmodule

`default_nettype wire

// ===== rtl/plcs_fin.sv =====
// Output stage: applies the quotient to the segment start, clamps and registers the result.
`default_nettype none

module plcs_fin (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  plcs_pkg::t_div_s           i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [plcs_pkg::PIX_W-1:0] o_stretched,
    output logic [plcs_pkg::PIX_W-1:0] o_binary
);
    import plcs_pkg::*;

    logic             r_v;
    logic [PIX_W-1:0] r_stretched;
    logic [PIX_W-1:0] r_binary;
    logic [PIX_W-1:0] n_stretched;
    logic [PIX_W-1:0] n_binary;
    logic [PIX_W+1:0] sum;
    logic             rdy;

    assign rdy = !r_v | i_ready;

    always_comb begin
        sum = i_data.neg ? ((PIX_W+2)'(i_data.start) - (PIX_W+2)'(i_data.sh))
                         : ((PIX_W+2)'(i_data.start) + (PIX_W+2)'(i_data.sh));
        // A zero-width segment yields its start value.
        if (i_data.width == '0) begin
            n_stretched = i_data.start;
        end else if (sum[PIX_W+1]) begin
            n_stretched = '0;
        end else if (sum > (PIX_W+2)'(MAXV)) begin
            n_stretched = MAXV;
        end else begin
            n_stretched = sum[PIX_W-1:0];
        end
        n_binary = i_data.bin ? MAXV : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_stretched <= n_stretched;
            r_binary    <= n_binary;
        end
    end

    assign o_ready     = rdy;
    assign o_valid     = r_v;
    assign o_stretched = r_stretched;
    assign o_binary    = r_binary;

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_contrast_stretch_top.sv =====
// Top level of the piecewise linear contrast stretch with binary threshold.
//
// Each input item is one pixel; each result item carries the pixel mapped
// through a three-segment linear curve through (0,0), (low_knee_in,
// low_knee_out), (high_knee_in,high_knee_out) and (max,max), plus the pixel
// binarized against threshold_level (0 below the level, all ones otherwise).
// Each segment multiplies before it divides, the division truncates toward
// zero, and a segment of zero width returns its start value. The block takes
// one item per clock cycle while the output side is ready: one stage
// selects the segment, one multiplies, PIX_W stages form a restoring
// divider that resolves one quotient bit each, and one stage adds,
// clamps and holds the result. Every stage has its own valid bit and
// moves when the stage after it is empty or moving, so bubbles are
// squeezed out and a stalled output holds its result while earlier stages
// keep filling. The knee points and level sit in an APB-style register file
// (registers at byte addresses 0, 4, 8, 12 and 16); they reset to 0, 0, max,
// max and 128, giving the identity curve, and must only be written while no
// item is in flight. Reset is synchronous and active low and empties the
// pipeline.
`default_nettype none

module piecewise_linear_contrast_stretch_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plcs_pkg::ADDR_W-1:0]  paddr,
    input  logic [plcs_pkg::DATA_W-1:0]  pwdata,
    output logic [plcs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [plcs_pkg::PIX_W-1:0]   i_pixel_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [plcs_pkg::PIX_W-1:0]   o_stretched_pixel,
    output logic [plcs_pkg::PIX_W-1:0]   o_binary_pixel
);
    import plcs_pkg::*;

    t_cfg   cfg;
    t_mul_s mul_data;
    t_div_s div_data;
    logic   mul_valid;
    logic   mul_ready;
    logic   div_valid;
    logic   div_ready;

    // Register file. The user must keep the settings static while items flow;
    // the block does not enforce it. Only the segment stage reads them directly.
    plcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Segment select and multiply (two stages).
    plcs_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel_in),
        .o_valid (mul_valid),
        .i_ready (mul_ready),
        .o_data  (mul_data)
    );

    // Division of the product by the segment width (PIX_W stages).
    plcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (mul_ready),
        .i_data  (mul_data),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_data  (div_data)
    );

    // Offset, clamp and output register.
    plcs_fin u_fin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .o_ready     (div_ready),
        .i_data      (div_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_stretched (o_stretched_pixel),
        .o_binary    (o_binary_pixel)
    );

    // A ready sink must never hold back the source: the ready chain passes it through.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled although the output side is ready");

    // The binary result is only ever all zeros or all ones.
    a_binary_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_binary_pixel == '0 || o_binary_pixel == MAXV))
        else $error("binary result is neither zero nor full scale");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== tb/sv/tb_piecewise_linear_contrast_stretch_top.sv =====
// Self-checking testbench for the piecewise linear contrast stretch with binary threshold.
`timescale 1ns / 1ps

module tb_piecewise_linear_contrast_stretch_top;

    import plcs_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int LATENCY     = PIX_W + 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 60;
    // The long receiver hold-off starts once this many pixels have gone in.
    localparam int HOLD_AT     = 40;
    localparam int HOLD_LEN    = 200;

    // One result item as the block presents it.
    typedef struct packed {
        logic [PIX_W-1:0] stretched;
        logic [PIX_W-1:0] binary;
    } t_pix_out;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid     = 1'b0;
    logic                o_ready;
    logic [PIX_W-1:0]    i_pixel_in  = '0;
    logic                o_valid;
    logic                i_ready     = 1'b0;
    logic [PIX_W-1:0]    o_stretched_pixel;
    logic [PIX_W-1:0]    o_binary_pixel;

    piecewise_linear_contrast_stretch_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_in        (i_pixel_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_stretched_pixel (o_stretched_pixel),
        .o_binary_pixel    (o_binary_pixel)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Testbench copy of the curve registers, updated as each write completes.
    t_cfg curve_cfg = '{low_knee_in: '0, low_knee_out: '0, high_knee_in: MAXV,
                        high_knee_out: MAXV, threshold_level: THR_RESET};

    logic [PIX_W-1:0] pixel_pend_q[$];
    t_pix_out         pixel_expect_q[$];

    int pixels_in   = 0;
    int fail_cnt    = 0;
    int cycle_cnt   = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    logic hold_on   = 1'b0;
    logic hold_done = 1'b0;
    int hold_left   = 0;
    logic [15:0] rdy_mask = 16'hFFFF;
    logic [3:0]  rdy_pos  = '0;
    int rdy_age = 0;

    // One linear segment: start plus rise*span/width with truncation toward
    // zero, or just the start value when the segment has no width.
    function automatic int seg_value(input int start, input int rise, input int span,
                                     input int width);
        if (width == 0)
            return start;
        return start + (rise * span) / width;
    endfunction

    // Expected result for one pixel under the current curve registers.
    function automatic t_pix_out predict_pixel(input logic [PIX_W-1:0] x);
        int xi, r1, s1, r2, s2, top, y;
        t_pix_out res;
        xi  = int'(x);
        r1  = int'(curve_cfg.low_knee_in);
        s1  = int'(curve_cfg.low_knee_out);
        r2  = int'(curve_cfg.high_knee_in);
        s2  = int'(curve_cfg.high_knee_out);
        top = int'(MAXV);
        // With the knees out of order the middle test fails for every x at
        // or above r1, so those pixels fall through to the third segment.
        if (xi < r1)
            y = seg_value(0, s1, xi, r1);
        else if (xi <= r2)
            y = seg_value(s1, s2 - s1, xi - r1, r2 - r1);
        else
            y = seg_value(s2, top - s2, xi - r2, top - r2);
        if (y < 0)
            y = 0;
        if (y > top)
            y = top;
        res.stretched = PIX_W'(y);
        res.binary    = (x < curve_cfg.threshold_level) ? '0 : MAXV;
        return res;
    endfunction

    // Knee and level values lean toward the ends of the range.
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return MAXV;
            2: return PIX_W'(1);
            3: return MAXV - 1'b1;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    // Random pixel: mostly uniform, the rest right around a knee or the level.
    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] anchor;
        if ($urandom_range(0, 9) < 7)
            return PIX_W'($urandom());
        case ($urandom_range(0, 2))
            0: anchor = curve_cfg.low_knee_in;
            1: anchor = curve_cfg.high_knee_in;
            default: anchor = curve_cfg.threshold_level;
        endcase
        return anchor + PIX_W'($urandom_range(0, 2)) - PIX_W'(1);
    endfunction

    // APB write: setup cycle, then the access cycle at whose end the register
    // takes the value.
    task automatic write_reg(input t_reg_idx idx, input logic [PIX_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LOW_KNEE_IN:   curve_cfg.low_knee_in     = val;
            REG_LOW_KNEE_OUT:  curve_cfg.low_knee_out    = val;
            REG_HIGH_KNEE_IN:  curve_cfg.high_knee_in    = val;
            REG_HIGH_KNEE_OUT: curve_cfg.high_knee_out   = val;
            REG_THRESHOLD:     curve_cfg.threshold_level = val;
            default: ;
        endcase
    endtask

    task automatic set_curve(input logic [PIX_W-1:0] r1, input logic [PIX_W-1:0] s1,
                             input logic [PIX_W-1:0] r2, input logic [PIX_W-1:0] s2,
                             input logic [PIX_W-1:0] thr);
        write_reg(REG_LOW_KNEE_IN, r1);
        write_reg(REG_LOW_KNEE_OUT, s1);
        write_reg(REG_HIGH_KNEE_IN, r2);
        write_reg(REG_HIGH_KNEE_OUT, s2);
        write_reg(REG_THRESHOLD, thr);
    endtask

    // Waits until every queued pixel is in and every result is back. Checked
    // on the falling edge so the clocked processes have settled.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pixel_pend_q.size() != 0 || i_valid || pixel_expect_q.size() != 0);
    endtask

    // Sender: bursts of random length separated by random gaps. A pixel is
    // predicted at the edge where it is accepted, so the registers it sees
    // are the ones the block uses.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                pixel_expect_q.push_back(predict_pixel(i_pixel_in));
                pixels_in <= pixels_in + 1;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pixel_pend_q.size() != 0) begin
                    i_valid    <= 1'b1;
                    i_pixel_in <= pixel_pend_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off of the receiver, counted here, so the pipeline fills
    // and pushes back on the sender.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                hold_on <= 1'b0;
        end else if (!hold_done && pixels_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_on   <= 1'b1;
            hold_done <= 1'b1;
        end
    end

    // Receiver: checks each result against the oldest prediction and stalls
    // on a rotating mask, redrawn when rdy_age wraps, and during the hold-off.
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_expect_q.size() == 0) begin
                if (fail_cnt < 10)
                    $display("%0t: result with none expected: stretched=%0d binary=%0d",
                             $realtime, o_stretched_pixel, o_binary_pixel);
                fail_cnt <= fail_cnt + 1;
            end else begin
                want = pixel_expect_q.pop_front();
                if (want.stretched !== o_stretched_pixel || want.binary !== o_binary_pixel) begin
                    if (fail_cnt < 10)
                        $display("%0t: mismatch: stretched exp %0d got %0d, binary exp %0d got %0d",
                                 $realtime, want.stretched, o_stretched_pixel,
                                 want.binary, o_binary_pixel);
                    fail_cnt <= fail_cnt + 1;
                end
            end
        end
        if (rdy_age == 63) begin
            rdy_age  <= 0;
            rdy_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
        end else begin
            rdy_age <= rdy_age + 1;
        end
        rdy_pos <= rdy_pos + 1'b1;
        i_ready <= rdy_mask[rdy_pos] && !hold_on;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_piecewise_linear_contrast_stretch_top: FAIL");
            $finish;
        end
    end

    initial begin
        logic [PIX_W-1:0] r1, r2;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Identity curve after reset: extremes, the level edge and alternating bits.
        pixel_pend_q = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd127, 8'd128, 8'h55, 8'hAA};
        wait_drained();

        // Zero-width middle segment with a falling step; level at zero.
        set_curve(8'd64, 8'd200, 8'd64, 8'd10, 8'd0);
        pixel_pend_q = '{8'd63, 8'd64, 8'd65, 8'd0, 8'd255};
        wait_drained();

        // Knees out of order; level at the top.
        set_curve(8'd200, 8'd50, 8'd100, 8'd220, 8'd255);
        pixel_pend_q = '{8'd199, 8'd200, 8'd150, 8'd101, 8'd254, 8'd255};
        wait_drained();

        // Zero-width first segment and a falling middle over the whole range.
        set_curve(8'd0, 8'd255, 8'd255, 8'd0, 8'd1);
        pixel_pend_q = '{8'd0, 8'd1, 8'd128, 8'd255};
        wait_drained();

        // Random curves, one setting per phase, knees in either order.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            r1 = pick_level();
            r2 = pick_level();
            if ($urandom_range(0, 2) != 0 && r2 < r1) begin
                r1 = r1 ^ r2;
                r2 = r1 ^ r2;
                r1 = r1 ^ r2;
            end
            set_curve(r1, pick_level(), r2, pick_level(), pick_level());
            for (int n = 0; n < PHASE_ITEMS; n++)
                pixel_pend_q.push_back(pick_pixel());
            wait_drained();
        end

        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_cnt == 0 && pixel_expect_q.size() == 0) begin
            $display("tb_piecewise_linear_contrast_stretch_top: PASS");
        end else begin
            $display("tb_piecewise_linear_contrast_stretch_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/plcs_pkg.sv
rtl/plcs_cfg.sv
rtl/plcs_seg.sv
rtl/plcs_div.sv
rtl/plcs_fin.sv
rtl/piecewise_linear_contrast_stretch_top.sv
tb/sv/tb_piecewise_linear_contrast_stretch_top.sv
